// ----- rtl/chunk_bounding_sphere_unit_assert.svh -----
// Assertion macros for the chunk bounding sphere unit checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CHUNK_BOUNDING_SPHERE_UNIT_ASSERT_SVH
`define CHUNK_BOUNDING_SPHERE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbs_pkg.sv -----
// Shared constants, types and the back-end state encoding for the chunk bounding
// sphere unit. No dependencies.
`default_nettype none
package cbs_pkg;
    localparam int MAX_CHUNK = 256;
    localparam int IDX_W     = $clog2(MAX_CHUNK);
    localparam int RAM_DEPTH = 2 * MAX_CHUNK;
    localparam int RAM_AW    = IDX_W + 1;
    localparam int Q_W       = 32;
    localparam int RAD_W     = 31;
    localparam int CNT_W     = 9;
    localparam int ROW_W     = 4 * Q_W;
    localparam int ROOT_STEPS = Q_W;
    localparam int STEP_W    = $clog2(ROOT_STEPS);

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic signed [Q_W-1:0] mid_x;
        logic signed [Q_W-1:0] mid_y;
        logic signed [Q_W-1:0] mid_z;
        logic [Q_W-1:0]        first_idx;
        logic [CNT_W-1:0]      num_splats;
    } t_chunk_desc;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_DIFF = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_ROOT = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_back_state;
endpackage
`default_nettype wire

// ----- rtl/cbs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module cbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cbs_front.sv -----
// Front end: accepts splats, tracks the chunk box, writes rows to the buffer
// and issues a chunk descriptor when a chunk closes. Uses cbs_pkg.
`default_nettype none
module cbs_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       i_room,
    input  wire logic [6*cbs_pkg::Q_W-1:0]  i_data,
    input  wire logic                       i_last,
    input  wire logic [cbs_pkg::CNT_W-1:0]  i_chunk_length,
    output logic                            o_accept,
    output logic                            o_wr_en,
    output logic [cbs_pkg::RAM_AW-1:0]      o_wr_addr,
    output logic [cbs_pkg::ROW_W-1:0]       o_wr_data,
    output logic                            o_push,
    output cbs_pkg::t_chunk_desc            o_desc
);
    import cbs_pkg::*;

    logic signed [Q_W-1:0] r_low [3];
    logic signed [Q_W-1:0] r_high [3];
    logic signed [Q_W-1:0] n_low [3];
    logic signed [Q_W-1:0] n_high [3];
    logic signed [Q_W-1:0] pos [3];
    logic signed [Q_W-1:0] scl [3];
    logic signed [Q_W-1:0] ext;
    logic signed [Q_W:0]   sum [3];
    logic signed [Q_W-1:0] center [3];
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      len;
    logic [Q_W-1:0]        r_start;
    logic                  r_bank;
    logic                  close;

    always_comb begin
        ext = '0;
        for (int k = 0; k < 3; k++) begin
            pos[k] = i_data[k*Q_W +: Q_W];
            scl[k] = i_data[(k+3)*Q_W +: Q_W];
            if (scl[k] > ext) begin
                ext = scl[k];
            end
            n_low[k]  = (pos[k] < r_low[k])  ? pos[k] : r_low[k];
            n_high[k] = (pos[k] > r_high[k]) ? pos[k] : r_high[k];
            sum[k]    = {n_low[k][Q_W-1], n_low[k]} + {n_high[k][Q_W-1], n_high[k]};
            center[k] = sum[k][Q_W:1];
        end
        if (i_chunk_length == '0) begin
            len = CNT_W'(1);
        end else if (i_chunk_length > CNT_W'(MAX_CHUNK)) begin
            len = CNT_W'(MAX_CHUNK);
        end else begin
            len = i_chunk_length;
        end
        cnt   = r_fill + CNT_W'(1);
        close = (cnt >= len) || i_last;
    end

    assign o_accept  = i_valid && i_room;
    assign o_wr_en   = o_accept;
    assign o_wr_addr = {r_bank, r_fill[IDX_W-1:0]};
    assign o_wr_data = {ext, pos[2], pos[1], pos[0]};
    assign o_push    = o_accept && close;

    always_comb begin
        o_desc.mid_x      = center[0];
        o_desc.mid_y      = center[1];
        o_desc.mid_z      = center[2];
        o_desc.first_idx  = r_start;
        o_desc.num_splats = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_low[k]  <= Q_MAX;
                r_high[k] <= Q_MIN;
            end
            r_fill  <= '0;
            r_start <= '0;
            r_bank  <= 1'b0;
        end else if (o_accept) begin
            if (close) begin
                for (int k = 0; k < 3; k++) begin
                    r_low[k]  <= Q_MAX;
                    r_high[k] <= Q_MIN;
                end
                r_fill  <= '0;
                r_bank  <= ~r_bank;
                r_start <= i_last ? '0 : r_start + Q_W'(cnt);
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_low[k]  <= n_low[k];
                    r_high[k] <= n_high[k];
                end
                r_fill <= cnt;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cbs_queue.sv -----
// Two-entry descriptor queue between the front and back ends; one entry per
// buffer bank. Uses cbs_pkg.
`default_nettype none
module cbs_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire cbs_pkg::t_chunk_desc  i_desc,
    input  wire logic                  i_pop,
    output cbs_pkg::t_chunk_desc       o_head,
    output logic                       o_not_empty,
    output logic                       o_room
);
    import cbs_pkg::*;

    t_chunk_desc r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_head      = r_entry[r_rd_ptr];
    assign o_not_empty = (r_count != 2'd0);
    assign o_room      = (r_count != 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cbs_back.sv -----
// Back end: walks the buffered rows of one chunk, computes each distance to the
// center with a bit-serial square root, keeps the radius and drives the output
// register. Uses cbs_pkg.
`default_nettype none
module cbs_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cbs_pkg::t_chunk_desc   i_head,
    input  wire logic                   i_not_empty,
    output logic                        o_pop,
    output logic                        o_rd_en,
    output logic [cbs_pkg::RAM_AW-1:0]  o_rd_addr,
    input  wire logic [cbs_pkg::ROW_W-1:0] i_rd_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [167:0]                o_data
);
    import cbs_pkg::*;

    t_back_state           r_state;
    logic                  r_bank;
    logic [CNT_W-1:0]      r_idx;
    logic [Q_W-1:0]        r_mag [3];
    logic [Q_W-1:0]        r_ext;
    logic [2*Q_W-1:0]      r_sq [3];
    logic [2*Q_W-1:0]      r_val;
    logic [Q_W+1:0]        r_rem;
    logic [Q_W-1:0]        r_root;
    logic [STEP_W-1:0]     r_step;
    logic [Q_W:0]          r_rad;
    logic [Q_W-1:0]        cen [3];
    logic signed [Q_W:0]   diff [3];
    logic [Q_W:0]          mag [3];
    logic [Q_W+3:0]        rem_sh;
    logic [Q_W+3:0]        trial;
    logic [Q_W:0]          cand;
    logic [RAD_W-1:0]      radius;
    logic                  load_out;

    always_comb begin
        cen[0] = i_head.mid_x;
        cen[1] = i_head.mid_y;
        cen[2] = i_head.mid_z;
        for (int k = 0; k < 3; k++) begin
            diff[k] = {i_rd_data[k*Q_W+Q_W-1], i_rd_data[k*Q_W +: Q_W]}
                    - {cen[k][Q_W-1], cen[k]};
            mag[k]  = diff[k][Q_W] ? (Q_W+1)'(-diff[k]) : diff[k];
        end
        rem_sh = {r_rem, r_val[2*Q_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        cand   = {1'b0, r_root} + {1'b0, r_ext};
        radius = (r_rad > (Q_W+1)'({RAD_W{1'b1}})) ? {RAD_W{1'b1}} : r_rad[RAD_W-1:0];
    end

    assign load_out  = (r_state == S_OUT) && (!o_valid || i_ready);
    assign o_pop     = load_out;
    assign o_rd_en   = (r_state == S_READ);
    assign o_rd_addr = {r_bank, r_idx[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= mag[k][Q_W-1:0];
                end
                r_ext <= i_rd_data[3*Q_W +: Q_W];
            end
            S_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= r_mag[k] * r_mag[k];
                end
            end
            S_SUM: begin
                r_val  <= r_sq[0] + r_sq[1] + r_sq[2];
                r_rem  <= '0;
                r_root <= '0;
            end
            S_ROOT: begin
                r_val <= {r_val[2*Q_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= (Q_W+2)'(rem_sh - trial);
                    r_root <= {r_root[Q_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[Q_W+1:0];
                    r_root <= {r_root[Q_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            o_data <= {i_head.num_splats, i_head.first_idx, radius,
                       i_head.mid_z, i_head.mid_y, i_head.mid_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_idx   <= '0;
            r_step  <= '0;
            r_rad   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_not_empty) begin
                        r_idx   <= '0;
                        r_rad   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_DIFF;
                S_DIFF: r_state <= S_MUL;
                S_MUL:  r_state <= S_SUM;
                S_SUM: begin
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (cand > r_rad) begin
                        r_rad <= cand;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                    if (r_idx + CNT_W'(1) == i_head.num_splats) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_bank  <= ~r_bank;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/chunk_bounding_sphere_unit.sv -----
// Chunk bounding sphere unit. Front end takes one splat word per cycle while a bank
// is free; the back end works through one splat at a time (read, difference, square,
// sum, 32 root steps, compare) in its bit-serial square root, with an idle and an output state per chunk.
// Reset (i_rst_n low, synchronous) empties the chunk, the queue and the output
// and sets the chunk length to 256; the buffer needs no clearing.
`default_nettype none
module chunk_bounding_sphere_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [cbs_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: pos_x, pos_y, pos_z, scale_x, scale_y, scale_z (32 bits each, low first)
    input  wire logic [191:0]              i_s_axis_tdata,
    input  wire logic                      i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // tdata: center x, center y, center z (32 each), radius (31), start index (32),
    // splat count (9), low first
    output logic [167:0]                   o_m_axis_tdata
);
    import cbs_pkg::*;

    // Chunk length register, reset to the largest chunk.
    logic [CNT_W-1:0] r_chunk_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_length <= CNT_W'(MAX_CHUNK);
        end else if (i_cfg_wr_en) begin
            r_chunk_length <= i_cfg_wr_data;
        end
    end

    logic              room;
    logic              accept;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
    logic              push;
    t_chunk_desc       push_desc;
    t_chunk_desc       head;
    logic              not_empty;
    logic              pop;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_data;

    // The front end fills one bank of the buffer while the back end walks the
    // other; a queue slot free means a bank free, so that is the input ready.
    assign o_s_axis_tready = room;

    cbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .i_room         (room),
        .i_data         (i_s_axis_tdata),
        .i_last         (i_s_axis_tlast),
        .i_chunk_length (r_chunk_length),
        .o_accept       (accept),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    cbs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cbs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_desc      (push_desc),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_room      (room)
    );

    cbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_not_empty (not_empty),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );
endmodule
`default_nettype wire

// ----- rtl/cbs_checker.sv -----
// Port-level checker for the chunk bounding sphere unit, bound to the top level.
// Uses the macros of chunk_bounding_sphere_unit_assert.svh.
`default_nettype none
`include "chunk_bounding_sphere_unit_assert.svh"
module cbs_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [167:0] o_m_axis_tdata
);
    // A stalled result word holds its value.
    `CBS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result word changed while stalled")
    // Every chunk holds at least one splat.
    `CBS_ASSERT_IMPL(a_count_nonzero, o_m_axis_tvalid, o_m_axis_tdata[167:159] != 9'd0, "empty chunk reported")
    // No chunk holds more splats than the buffer bank.
    `CBS_ASSERT_IMPL(a_count_max, o_m_axis_tvalid, o_m_axis_tdata[167:159] <= 9'd256, "chunk count too large")
    // A result word leaves only through a handshake.
    `CBS_ASSERT_IMPL(a_out_drop, $fell(o_m_axis_tvalid), $past(i_m_axis_tready), "result word dropped")
endmodule

bind chunk_bounding_sphere_unit cbs_checker u_cbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
